/* hdl/global_perceptron_branch_predictor_unit_macros.svh */
// assertion helpers for the perceptron predictor
`ifndef GLOBAL_PERCEPTRON_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define GLOBAL_PERCEPTRON_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// same-cycle implication
`define GPBP_ASSERT_NOW(lbl, clk_s, rstn_s, a, b, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |-> (b)) \
    else $error(msg);

// next-cycle implication
`define GPBP_ASSERT_NEXT(lbl, clk_s, rstn_s, a, b, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |=> (b)) \
    else $error(msg);

`endif

/* hdl/gpbp_pkg.sv */
package gpbp_pkg;

  localparam int N_ROWS_DEF      = 256;
  localparam int HIST_DEPTH_DEF  = 32;
  localparam int WEIGHT_BITS_DEF = 8;

  // weights summed per registered partial sum
  localparam int GROUP_SIZE = 8;

  localparam int ADDR_W    = 32;
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 8;

  // controller commands to the datapath
  typedef struct packed {
    logic capture;  // take the input beat and read its row
    logic psum;     // register partial sums
    logic commit;   // decide, write back on a miss, present result
    logic clr;      // write reset row at the clear address
  } ctl_t;

  // datapath status to the controller
  typedef struct packed {
    logic out_busy; // result register holds an untaken beat
  } sts_t;

endpackage

/* hdl/gpbp_ctrl.sv */
module gpbp_ctrl #(
  parameter int N_ROWS   = gpbp_pkg::N_ROWS_DEF,
  parameter int ROW_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gpbp_pkg::sts_t      sts,
  output gpbp_pkg::ctl_t      ctl,
  output logic [ROW_BITS-1:0] clr_addr
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DECIDE
  } state_t;

  state_t              state_r;
  logic [ROW_BITS-1:0] cnt_r;

  assign in_ready    = (state_r == ST_IDLE);
  assign clr_addr    = cnt_r;
  assign ctl.clr     = (state_r == ST_CLEAR);
  assign ctl.capture = (state_r == ST_IDLE) && in_valid;
  assign ctl.psum    = (state_r == ST_SUM);
  assign ctl.commit  = (state_r == ST_DECIDE) && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == ROW_BITS'(N_ROWS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!sts.out_busy) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

endmodule

/* hdl/gpbp_dpath.sv */
module gpbp_dpath #(
  parameter int N_ROWS      = gpbp_pkg::N_ROWS_DEF,
  parameter int HIST_DEPTH  = gpbp_pkg::HIST_DEPTH_DEF,
  parameter int WEIGHT_BITS = gpbp_pkg::WEIGHT_BITS_DEF,
  parameter int ROW_BITS    = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gpbp_pkg::ctl_t                  ctl,
  output gpbp_pkg::sts_t                  sts,
  input  logic [ROW_BITS-1:0]             clr_addr,
  input  logic [gpbp_pkg::IN_DATA_W-1:0]  in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gpbp_pkg::OUT_DATA_W-1:0] out_data
);

  localparam int WB     = WEIGHT_BITS;
  localparam int H      = HIST_DEPTH;
  localparam int ROW_W  = (H + 1) * WB;
  localparam int GS     = gpbp_pkg::GROUP_SIZE;
  localparam int NG     = (H + GS - 1) / GS;
  localparam int PS_W   = WB + 4;
  localparam int SUM_W  = WB + 8;

  localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};

  logic [ROW_W-1:0] mem [N_ROWS];
  logic [ROW_W-1:0] rd_row_r;

  logic [ROW_BITS-1:0] row_r;
  logic                taken_r;
  logic [H-1:0]        hist_out_r;
  logic [H-1:0]        hist_fill_r;

  logic signed [PS_W-1:0] psum_r [NG];
  logic signed [PS_W-1:0] psum_nxt [NG];

  logic signed [SUM_W-1:0] total;
  logic                    pred;
  logic                    miss;
  logic [ROW_W-1:0]        trained;

  logic                out_valid_r;
  logic                pred_r;
  logic                miss_r;

  logic [ROW_BITS-1:0] in_row;
  logic                we;
  logic [ROW_BITS-1:0] waddr;
  logic [ROW_W-1:0]    wdata;

  assign in_row = in_data[ROW_BITS-1:0] & ROW_BITS'(N_ROWS - 1);

  // partial sums, one per group of history weights
  always_comb begin
    logic signed [WB-1:0]   w;
    logic signed [PS_W-1:0] acc;
    logic signed [PS_W-1:0] term;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < H) begin
          w = rd_row_r[(g * GS + k + 1) * WB +: WB];
          if (!hist_fill_r[g * GS + k]) begin
            term = '0;
          end else if (hist_out_r[g * GS + k]) begin
            term = PS_W'(w);
          end else begin
            term = -PS_W'(w);
          end
          acc = acc + term;
        end
      end
      psum_nxt[g] = acc;
    end
  end

  // bias plus group sums, then training of the row
  always_comb begin
    logic signed [WB-1:0] w;
    logic                 up;
    total = SUM_W'($signed(rd_row_r[WB-1:0]));
    for (int g = 0; g < NG; g++) begin
      total = total + SUM_W'(psum_r[g]);
    end
    pred = !total[SUM_W-1];
    miss = (pred != taken_r);

    trained = rd_row_r;
    w = rd_row_r[WB-1:0];
    if (taken_r) begin
      if (w != W_MAX) trained[WB-1:0] = w + 1'b1;
    end else begin
      if (w != W_MIN) trained[WB-1:0] = w - 1'b1;
    end
    for (int i = 0; i < H; i++) begin
      w  = rd_row_r[(i + 1) * WB +: WB];
      up = (taken_r == hist_out_r[i]);
      if (hist_fill_r[i]) begin
        if (up) begin
          if (w != W_MAX) trained[(i + 1) * WB +: WB] = w + 1'b1;
        end else begin
          if (w != W_MIN) trained[(i + 1) * WB +: WB] = w - 1'b1;
        end
      end
    end
  end

  assign we    = ctl.clr || (ctl.commit && miss);
  assign waddr = ctl.clr ? clr_addr : row_r;
  assign wdata = ctl.clr ? ROW_W'(1) : trained;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.capture) begin
      rd_row_r <= mem[in_row];
      row_r    <= in_row;
      taken_r  <= in_data[gpbp_pkg::ADDR_W];
    end
    if (ctl.psum) begin
      for (int g = 0; g < NG; g++) begin
        psum_r[g] <= psum_nxt[g];
      end
    end
    if (ctl.commit) begin
      pred_r <= pred;
      miss_r <= miss;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_out_r  <= '0;
      hist_fill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.commit) begin
        hist_out_r  <= (hist_out_r >> 1) | (H'(taken_r) << (H - 1));
        hist_fill_r <= (hist_fill_r >> 1) | (H'(1'b1) << (H - 1));
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = {{(gpbp_pkg::OUT_DATA_W - 2){1'b0}}, miss_r, pred_r};

endmodule

/* hdl/global_perceptron_branch_predictor_unit.sv */
// an input beat passes row read, partial sums and decide, each registered, before its result beat
// one branch at a time: a new beat is taken only after the read / sum / decide sequence
// of the controller ends; a result beat still waiting holds the decide step
// reset: synchronous active-low; afterwards a clearing pass writes every row,
// with in_tready low until it ends
`include "global_perceptron_branch_predictor_unit_macros.svh"

module global_perceptron_branch_predictor_unit #(
  parameter int N_ROWS      = gpbp_pkg::N_ROWS_DEF,
  parameter int HIST_DEPTH  = gpbp_pkg::HIST_DEPTH_DEF,
  parameter int WEIGHT_BITS = gpbp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] branch_address, [32] taken, rest zero
  input  logic [gpbp_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] predicted_taken, [1] mispredicted, rest zero
  output logic [gpbp_pkg::OUT_DATA_W-1:0] out_tdata
);

  // row index width, at least one bit
  localparam int ROW_BITS = (N_ROWS > 1) ? $clog2(N_ROWS) : 1;

  gpbp_pkg::ctl_t      ctl;
  gpbp_pkg::sts_t      sts;
  logic [ROW_BITS-1:0] clr_addr;

  // sequencer: clear pass, accept, sum, decide and write back
  gpbp_ctrl #(
    .N_ROWS   (N_ROWS),
    .ROW_BITS (ROW_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  // weight memory, history, adder tree, training and result register
  gpbp_dpath #(
    .N_ROWS      (N_ROWS),
    .HIST_DEPTH  (HIST_DEPTH),
    .WEIGHT_BITS (WEIGHT_BITS),
    .ROW_BITS    (ROW_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .clr_addr  (clr_addr),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // one branch in flight: no new beat right after an accepted one
  `GPBP_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "overlap")
  // a commit always leaves a result beat waiting
  `GPBP_ASSERT_NEXT(a_commit_out, clk, rst_n, ctl.commit, out_tvalid, "commit without result beat")
  // no clearing write while an item is being handled
  `GPBP_ASSERT_NOW(a_clr_excl, clk, rst_n, ctl.clr, !ctl.commit && !in_tready, "clear overlap")

endmodule
